FILE: rtl/core/rei_pkg.sv
// Types and constants shared by the rotary encoder interface.
// Holds the channel payload structs, register indexes and reset values.
// No dependencies.
package rei_pkg;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_COUNT_LIMIT   = 2'd0,
    CFG_GLITCH_CYCLES = 2'd1,
    CFG_DEBOUNCE_MS   = 2'd2
  } cfg_idx_e;

  localparam logic [14:0] COUNT_LIMIT_RST   = 15'd32000;
  localparam logic [9:0]  GLITCH_CYCLES_RST = 10'd100;
  localparam logic [15:0] DEBOUNCE_MS_RST   = 16'd50;

  localparam int STEP_MAX = 8191;
  localparam int STEP_MIN = -8192;

  typedef struct packed {
    logic enc_a;
    logic enc_b;
    logic button_level;
    logic ms_tick;
    logic read_steps;
    logic poll_button;
  } in_item_t;

  typedef struct packed {
    logic signed [13:0] detent_steps;
    logic               steps_valid;
    logic               button_event;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] wdata;
  } cfg_wr_t;

endpackage

FILE: rtl/core/rei_chan_if.sv
// Valid/ready channel used for the input, result and configuration ports.
// The payload type is a parameter; the structs come from rei_pkg.
interface rei_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/rei_glitch_filter.sv
// Glitch filter for one encoder channel: a new level is taken once it has
// held for the programmed number of samples. Uses no package items.
module rei_glitch_filter (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       level_i,
  input  logic [9:0] glitch_cycles_i,
  output logic       filt_q_o,
  output logic       filt_d_o
);

  logic       filt_q, filt_d;
  logic [9:0] hold_q, hold_d;
  logic [10:0] hold_inc;

  assign hold_inc = {1'b0, hold_q} + 11'd1;

  always_comb begin
    filt_d = filt_q;
    hold_d = hold_q;
    if (en_i) begin
      if (level_i == filt_q) begin
        hold_d = '0;
      end else if (hold_inc >= {1'b0, glitch_cycles_i}) begin
        filt_d = level_i;
        hold_d = '0;
      end else begin
        hold_d = hold_inc[9:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q <= 1'b0;
      hold_q <= '0;
    end else begin
      filt_q <= filt_d;
      hold_q <= hold_d;
    end
  end

  assign filt_q_o = filt_q;
  assign filt_d_o = filt_d;

endmodule

FILE: rtl/core/rotary_encoder_interface.sv
// Rotary encoder interface: X4 quadrature counter with detent reads and a
// debounced button. Depends on rei_pkg, rei_chan_if and rei_glitch_filter.
//
//   port    direction  payload       purpose
//   in_i    sink       in_item_t     one pin sample and its requests
//   out_o   source     out_item_t    one result for each sample
//   cfg_i   sink       cfg_wr_t      register writes, always ready
//
// One sample is taken per cycle while in_i.ready is high; its result is
// registered; sustained rate is one item per clock while out_o keeps up.
// Filter, counter and button state update in the cycle a sample is accepted.
// A two-entry output buffer (result register plus skid) lets sampling go on
// while a result waits; in_i.ready drops only when both entries are full.
// Reset is asynchronous and restores the register defaults.
module rotary_encoder_interface #(
  parameter int COUNTS_PER_DETENT_LOG2 = 2,
  parameter int COUNT_WIDTH            = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  rei_chan_if.sink   in_i,
  rei_chan_if.source out_o,
  rei_chan_if.sink   cfg_i
);

  localparam int CmpW = ((COUNT_WIDTH > 15) ? COUNT_WIDTH : 15) + 1;
  localparam int DW   = COUNT_WIDTH + 1;
  localparam int ExtW = 34;
  localparam logic [DW-1:0] RemMask = DW'((64'd1 << COUNTS_PER_DETENT_LOG2) - 64'd1);

  // Configuration registers.
  logic [14:0] count_limit_q;
  logic [9:0]  glitch_cycles_q;
  logic [15:0] debounce_ms_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_limit_q   <= rei_pkg::COUNT_LIMIT_RST;
      glitch_cycles_q <= rei_pkg::GLITCH_CYCLES_RST;
      debounce_ms_q   <= rei_pkg::DEBOUNCE_MS_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.data.index)
        rei_pkg::CFG_COUNT_LIMIT:   count_limit_q   <= cfg_i.data.wdata[14:0];
        rei_pkg::CFG_GLITCH_CYCLES: glitch_cycles_q <= cfg_i.data.wdata[9:0];
        rei_pkg::CFG_DEBOUNCE_MS:   debounce_ms_q   <= cfg_i.data.wdata;
        default: ;
      endcase
    end
  end

  logic in_acc;
  assign in_acc = in_i.valid & in_i.ready;

  // Channel filters.
  logic filt_a_q, filt_a_d, filt_b_q, filt_b_d;

  rei_glitch_filter u_filt_a (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (in_acc),
    .level_i         (in_i.data.enc_a),
    .glitch_cycles_i (glitch_cycles_q),
    .filt_q_o        (filt_a_q),
    .filt_d_o        (filt_a_d)
  );

  rei_glitch_filter u_filt_b (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (in_acc),
    .level_i         (in_i.data.enc_b),
    .glitch_cycles_i (glitch_cycles_q),
    .filt_q_o        (filt_b_q),
    .filt_d_o        (filt_b_d)
  );

  // Quadrature counter.
  logic [COUNT_WIDTH-1:0] raw_count_q, raw_count_d, raw_step;
  logic [CmpW-1:0]        step_ext, lim_pos, lim_neg;
  logic                   chg_a, chg_b, count_up;

  assign chg_a    = filt_a_d != filt_a_q;
  assign chg_b    = filt_b_d != filt_b_q;
  assign count_up = chg_a ? (filt_a_d != filt_b_d) : (filt_b_d == filt_a_d);
  assign raw_step = count_up ? raw_count_q + COUNT_WIDTH'(1) : raw_count_q + {COUNT_WIDTH{1'b1}};
  assign step_ext = {{(CmpW-COUNT_WIDTH){raw_step[COUNT_WIDTH-1]}}, raw_step};
  assign lim_pos  = {{(CmpW-15){1'b0}}, count_limit_q};
  assign lim_neg  = -lim_pos;

  always_comb begin
    raw_count_d = raw_count_q;
    if (in_acc && (chg_a != chg_b)) begin
      if ((step_ext == lim_pos) || (step_ext == lim_neg)) begin
        raw_count_d = '0;
      end else begin
        raw_count_d = raw_step;
      end
    end
  end

  // Detent read: delta divided toward zero, remainder left in the counter.
  logic [COUNT_WIDTH-1:0] consumed_q, consumed_d, delta;
  logic [DW-1:0]          delta_ext, rounded, whole;
  logic signed [ExtW-1:0] det_ext;
  logic signed [13:0]     steps;

  assign delta     = raw_count_d - consumed_q;
  assign delta_ext = {delta[COUNT_WIDTH-1], delta};
  assign rounded   = delta_ext + (delta[COUNT_WIDTH-1] ? RemMask : '0);
  assign whole     = rounded & ~RemMask;
  assign det_ext   = ExtW'($signed(rounded) >>> COUNTS_PER_DETENT_LOG2);

  always_comb begin
    if (det_ext > ExtW'(rei_pkg::STEP_MAX)) begin
      steps = 14'(rei_pkg::STEP_MAX);
    end else if (det_ext < ExtW'(rei_pkg::STEP_MIN)) begin
      steps = 14'(rei_pkg::STEP_MIN);
    end else begin
      steps = det_ext[13:0];
    end
  end

  assign consumed_d = (in_acc && in_i.data.read_steps) ?
                      consumed_q + whole[COUNT_WIDTH-1:0] : consumed_q;

  // Button debounce.
  logic        btn_last_q, btn_last_d, btn_stable_q, btn_stable_d;
  logic        press_pending_q, press_pending_d, btn_event;
  logic [15:0] ms_since_q, ms_since_d;

  always_comb begin
    btn_last_d      = btn_last_q;
    btn_stable_d    = btn_stable_q;
    ms_since_d      = ms_since_q;
    press_pending_d = press_pending_q;
    btn_event       = 1'b0;
    if (in_acc) begin
      if (in_i.data.button_level != btn_last_q) begin
        btn_last_d = in_i.data.button_level;
        ms_since_d = '0;
      end else if (in_i.data.ms_tick && (ms_since_q != 16'hFFFF)) begin
        ms_since_d = ms_since_q + 16'd1;
      end
      if ((ms_since_d > debounce_ms_q) && (in_i.data.button_level != btn_stable_q)) begin
        btn_stable_d = in_i.data.button_level;
        if (!in_i.data.button_level) begin
          press_pending_d = 1'b1;
        end
      end
      // A press latched in this sample can be handed out by this poll.
      if (in_i.data.poll_button && press_pending_d) begin
        press_pending_d = 1'b0;
        btn_event       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_count_q     <= '0;
      consumed_q      <= '0;
      btn_last_q      <= 1'b1;
      btn_stable_q    <= 1'b1;
      ms_since_q      <= '0;
      press_pending_q <= 1'b0;
    end else begin
      raw_count_q     <= raw_count_d;
      consumed_q      <= consumed_d;
      btn_last_q      <= btn_last_d;
      btn_stable_q    <= btn_stable_d;
      ms_since_q      <= ms_since_d;
      press_pending_q <= press_pending_d;
    end
  end

  // Result word and output buffer.
  rei_pkg::out_item_t res, out_q, out_d, skid_q, skid_d;
  logic out_vld_q, out_vld_d, skid_vld_q, skid_vld_d, out_pop;

  assign res.detent_steps = in_i.data.read_steps ? steps : '0;
  assign res.steps_valid  = in_i.data.read_steps;
  assign res.button_event = btn_event;

  assign out_pop     = out_vld_q & out_o.ready;
  assign in_i.ready  = ~skid_vld_q;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_comb begin
    out_vld_d  = out_vld_q;
    skid_vld_d = skid_vld_q;
    out_d      = out_q;
    skid_d     = skid_q;
    if (skid_vld_q) begin
      if (out_pop) begin
        out_d      = skid_q;
        skid_vld_d = 1'b0;
      end
    end else if (in_acc) begin
      if (!out_vld_q || out_pop) begin
        out_d     = res;
        out_vld_d = 1'b1;
      end else begin
        skid_d     = res;
        skid_vld_d = 1'b1;
      end
    end else if (out_pop) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

`ifndef SYNTHESIS
  // The skid entry is only ever filled behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid while result register empty");

  // A press is latched only when the debounced level goes low.
  a_press_on_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(press_pending_q) |-> !btn_stable_q)
    else $error("press latched without a debounced low level");

  // The counter moves only on an accepted sample.
  a_count_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(raw_count_q) |-> $past(in_acc))
    else $error("counter changed without an accepted sample");
`endif

endmodule
